[hdl/adcwm_pkg.sv]
package adcwm_pkg;

	// Sample and window widths
	localparam int unsigned ADC_BITS    = 12;
	localparam int unsigned SAMPLE_W    = 13;
	localparam int unsigned CNT_W       = 11;
	localparam int unsigned ACC_W       = 22;
	localparam int unsigned MAX_SAMPLES = 1024;
	localparam int unsigned VOLT_W      = 16;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_W     = 11;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN = 1'd1;
	localparam logic [CFG_W-1:0]     WIN_LEN_RST = 11'd64;

	// Calibration polynomial scaled by 1e10:
	// mV = (C1*K - C2mag*K^2 + C0 + SCALE/2) / SCALE
	localparam int unsigned PROD_W = 33;
	localparam int unsigned TERM_W = 37;
	localparam int unsigned NUM_W  = 49;
	localparam int unsigned DIVS_W = 34;
	localparam logic [20:0]       POLY_C2_MAG  = 21'd1604208;
	localparam logic [TERM_W-1:0] POLY_C1      = 37'd119180700000;
	localparam logic [42:0]       POLY_C0_HALF = 43'd6029925000000;
	localparam logic [DIVS_W-1:0] MV_SCALE     = 34'd10000000000;

	// Window-end request into the arithmetic unit
	typedef struct packed {
		logic                start;
		logic [ACC_W-1:0]    acc;
		logic [CNT_W-1:0]    count;
		logic [ADC_BITS-1:0] span;
	} calc_req_t;

	// Finished window result
	typedef struct packed {
		logic                done;
		logic [ADC_BITS-1:0] mean;
		logic [ADC_BITS-1:0] span;
		logic [VOLT_W-1:0]   voltage;
	} calc_res_t;

endpackage

[hdl/adcwm_calc.sv]
module adcwm_calc (
	input  logic                 clk,
	input  logic                 arst_n,
	input  adcwm_pkg::calc_req_t req,
	input  logic                 ack,
	output adcwm_pkg::calc_res_t res
);
	import adcwm_pkg::*;

	typedef enum logic [6:0] {
		C_IDLE = 7'b0000001,
		C_DIV  = 7'b0000010,
		C_MUL1 = 7'b0000100,
		C_MUL2 = 7'b0001000,
		C_ADD  = 7'b0010000,
		C_VDIV = 7'b0100000,
		C_DONE = 7'b1000000
	} calc_state_t;

	calc_state_t         state_q;
	logic [3:0]          step_q;
	logic [CNT_W-1:0]    rem_q;
	logic [ADC_BITS-1:0] dq_q;
	logic [CNT_W-1:0]    div_q;
	logic [ADC_BITS-1:0] span_q;
	logic [ADC_BITS-1:0] mean_q;
	logic [ADC_BITS-1:0] kmul_q;
	logic [PROD_W-1:0]   prod_q;
	logic [TERM_W-1:0]   term_q;
	logic [NUM_W-1:0]    num_q;
	logic [DIVS_W-1:0]   vrem_q;
	logic [VOLT_W-1:0]   vq_q;

	logic [CNT_W:0]      trial;
	logic                qbit;
	logic [CNT_W-1:0]    rem_nx;
	logic [ADC_BITS-1:0] dq_nx;
	logic [PROD_W-1:0]   prod_nx;
	logic [NUM_W-1:0]    num_nx;
	logic [NUM_W-1:0]    num_biased;
	logic [DIVS_W:0]     vtrial;
	logic                vbit;
	logic [DIVS_W-1:0]   vrem_nx;

	// Mean divide: one quotient bit per cycle, restoring
	always_comb begin
		trial  = {rem_q, dq_q[ADC_BITS-1]};
		qbit   = (trial >= {1'b0, div_q});
		rem_nx = qbit ? CNT_W'(trial - {1'b0, div_q}) : CNT_W'(trial);
		dq_nx  = {dq_q[ADC_BITS-2:0], qbit};
	end

	// Shift-add multiply, one multiplier bit per cycle, MSB first
	always_comb begin
		prod_nx    = {prod_q[PROD_W-2:0], 1'b0}
			+ (kmul_q[ADC_BITS-1] ? PROD_W'(POLY_C2_MAG) : '0);
		num_nx     = {num_q[NUM_W-2:0], 1'b0}
			+ (kmul_q[ADC_BITS-1] ? NUM_W'(term_q) : '0);
		num_biased = num_q + NUM_W'(POLY_C0_HALF);
	end

	// Millivolt divide by the scale: one quotient bit per cycle
	always_comb begin
		vtrial  = {vrem_q, vq_q[VOLT_W-1]};
		vbit    = (vtrial >= {1'b0, MV_SCALE});
		vrem_nx = vbit ? DIVS_W'(vtrial - {1'b0, MV_SCALE}) : DIVS_W'(vtrial);
	end

	// Sequence the phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (req.start) begin
						state_q <= C_DIV;
						step_q  <= 4'(ADC_BITS - 1);
					end
				end
				C_DIV: begin
					step_q <= step_q - 4'd1;
					if (step_q == 4'd0) begin
						state_q <= C_MUL1;
						step_q  <= 4'(ADC_BITS - 1);
					end
				end
				C_MUL1: begin
					step_q <= step_q - 4'd1;
					if (step_q == 4'd0) begin
						state_q <= C_MUL2;
						step_q  <= 4'(ADC_BITS - 1);
					end
				end
				C_MUL2: begin
					step_q <= step_q - 4'd1;
					if (step_q == 4'd0) begin
						state_q <= C_ADD;
					end
				end
				C_ADD: begin
					state_q <= C_VDIV;
					step_q  <= 4'(VOLT_W - 1);
				end
				C_VDIV: begin
					step_q <= step_q - 4'd1;
					if (step_q == 4'd0) begin
						state_q <= C_DONE;
					end
				end
				C_DONE: begin
					if (ack) begin
						state_q <= C_IDLE;
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	// Datapath shift registers
	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (req.start) begin
					rem_q  <= CNT_W'(req.acc[ACC_W-1:ADC_BITS]);
					dq_q   <= req.acc[ADC_BITS-1:0];
					div_q  <= req.count;
					span_q <= req.span;
				end
			end
			C_DIV: begin
				rem_q <= rem_nx;
				dq_q  <= dq_nx;
				if (step_q == 4'd0) begin
					mean_q <= dq_nx;
					kmul_q <= dq_nx;
					prod_q <= '0;
				end
			end
			C_MUL1: begin
				prod_q <= prod_nx;
				kmul_q <= {kmul_q[ADC_BITS-2:0], 1'b0};
				if (step_q == 4'd0) begin
					term_q <= POLY_C1 - TERM_W'(prod_nx);
					kmul_q <= mean_q;
					num_q  <= '0;
				end
			end
			C_MUL2: begin
				num_q  <= num_nx;
				kmul_q <= {kmul_q[ADC_BITS-2:0], 1'b0};
			end
			C_ADD: begin
				// Polynomial stays positive over the sample range; quotient fits 16 bits
				vrem_q <= DIVS_W'(num_biased[NUM_W-1:VOLT_W]);
				vq_q   <= num_biased[VOLT_W-1:0];
			end
			C_VDIV: begin
				vrem_q <= vrem_nx;
				vq_q   <= {vq_q[VOLT_W-2:0], vbit};
			end
			default: begin
			end
		endcase
	end

	assign res.done    = (state_q == C_DONE);
	assign res.mean    = mean_q;
	assign res.span    = span_q;
	assign res.voltage = vq_q;

endmodule

[hdl/adc_window_mean_span_voltage_top.sv]
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall   | sample
// out     | output    | out_valid/out_stall | mean_raw, span_raw, voltage_mv
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// A sample that does not close a window is taken at once; the next may follow straight after it.
// A window-closing sample starts the serial unit: a restoring divide for the mean, a two-pass
// shift-add multiply, an offset add and a scale divide, then the hand-off; in_stall stays high
// throughout, and longer while an earlier result is still held by out_stall.
// The result sits in an output register, so the next window runs while it waits on out_stall.
// arst_n clears window state, configuration (enable 0, window length 64) and out_valid.
module adc_window_mean_span_voltage_top (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic signed [adcwm_pkg::SAMPLE_W-1:0]    sample,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [adcwm_pkg::ADC_BITS-1:0]           mean_raw,
	output logic [adcwm_pkg::ADC_BITS-1:0]           span_raw,
	output logic [adcwm_pkg::VOLT_W-1:0]             voltage_mv,
	input  logic                                     cfg_we,
	input  logic [adcwm_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [adcwm_pkg::CFG_W-1:0]              cfg_data
);
	import adcwm_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_CALC = 2'b10
	} top_state_t;

	top_state_t          state_q;
	logic                enable_q;
	logic [CFG_W-1:0]    win_len_q;
	logic [ACC_W-1:0]    acc_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [ADC_BITS-1:0] min_q;
	logic [ADC_BITS-1:0] max_q;
	logic                primed_q;
	logic                out_valid_q;
	logic [ADC_BITS-1:0] mean_q;
	logic [ADC_BITS-1:0] span_q;
	logic [VOLT_W-1:0]   volt_q;

	logic                in_take;
	logic [ADC_BITS-1:0] k;
	logic [ACC_W-1:0]    acc_nx;
	logic [CNT_W-1:0]    cnt_nx;
	logic [ADC_BITS-1:0] min_nx;
	logic [ADC_BITS-1:0] max_nx;
	logic [CNT_W-1:0]    win_len;
	logic                close;
	logic                load_out;
	calc_req_t           req;
	calc_res_t           res;

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;

	// Clamp the sample and form the next window statistics
	always_comb begin
		k      = sample[SAMPLE_W-1] ? '0 : sample[ADC_BITS-1:0];
		acc_nx = acc_q + ACC_W'(k);
		cnt_nx = cnt_q + CNT_W'(1);
		min_nx = (k < min_q) ? k : min_q;
		max_nx = (k > max_q) ? k : max_q;
		if (win_len_q == '0) begin
			win_len = CNT_W'(1);
		end else if (win_len_q > CNT_W'(MAX_SAMPLES)) begin
			win_len = CNT_W'(MAX_SAMPLES);
		end else begin
			win_len = win_len_q;
		end
		close = enable_q && primed_q && (cnt_nx >= win_len);
	end

	assign req.start = in_take && close;
	assign req.acc   = acc_nx;
	assign req.count = cnt_nx;
	assign req.span  = max_nx - min_nx;

	adcwm_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ack    (load_out),
		.res    (res)
	);

	assign load_out = (state_q == S_CALC) && res.done && (!out_valid_q || !out_stall);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			win_len_q <= WIN_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:  enable_q  <= cfg_data[0];
				REG_WIN_LEN: win_len_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Window state: drop the priming read, accumulate, clear at window end or when off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			acc_q    <= '0;
			cnt_q    <= '0;
			min_q    <= '1;
			max_q    <= '0;
			primed_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (!enable_q || close) begin
							acc_q    <= '0;
							cnt_q    <= '0;
							min_q    <= '1;
							max_q    <= '0;
							primed_q <= 1'b0;
							if (close) begin
								state_q <= S_CALC;
							end
						end else if (!primed_q) begin
							primed_q <= 1'b1;
						end else begin
							acc_q <= acc_nx;
							cnt_q <= cnt_nx;
							min_q <= min_nx;
							max_q <= max_nx;
						end
					end
				end
				S_CALC: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: hold the transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			mean_q <= res.mean;
			span_q <= res.span;
			volt_q <= res.voltage;
		end
	end

	assign out_valid  = out_valid_q;
	assign mean_raw   = mean_q;
	assign span_raw   = span_q;
	assign voltage_mv = volt_q;

endmodule
